// ----- hdl/mbp_pkg.sv -----
// shared types for the msb-first bit packer
package mbp_pkg;

	localparam int unsigned FieldWidthBits = 6;
	localparam int unsigned FieldValueBits = 32;
	localparam int unsigned ByteBits = 8;
	localparam int unsigned PendBits = 7;

	typedef enum logic [0:0] {
		ACT_APPEND = 1'b0,
		ACT_FLUSH  = 1'b1
	} action_t;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic ack;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic load_emits;
		logic emit_last;
	} dp_status_t;

endpackage

// ----- hdl/mbp_ctrl.sv -----
// controller state machine: accept one item, then hand out its bytes
module mbp_ctrl import mbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output logic       in_ready,
	output logic       out_valid,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && status.load_emits) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_ready && status.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.ack   = out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- hdl/mbp_dp.sv -----
// datapath: bit accumulator, bit count and byte extraction
module mbp_dp import mbp_pkg::*; #(
	parameter int unsigned MAX_FIELD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	input  action_t                   action,
	input  logic [FieldWidthBits-1:0] field_width,
	input  logic [FieldValueBits-1:0] field_value,
	output dp_status_t                status,
	output logic [ByteBits-1:0]       out_byte
);

	localparam int unsigned AccW = MAX_FIELD_BITS + PendBits;
	localparam int unsigned CntW = $clog2(AccW + 1);
	localparam logic [FieldWidthBits-1:0] MaxW = FieldWidthBits'(MAX_FIELD_BITS);

	logic [AccW-1:0] acc_q;
	logic [CntW-1:0] cnt_q;

	logic [FieldWidthBits-1:0] wsat;
	logic [PendBits-1:0]       pend;
	logic [ByteBits-1:0]       flush_byte;
	logic [AccW-1:0]           val_ext;
	logic [AccW-1:0]           val_mask;
	logic [AccW-1:0]           acc_d;
	logic [CntW-1:0]           cnt_d;
	logic [CntW-1:0]           emit_sh;

	// pending bits are only the low cnt bits; cnt is below 8 when idle
	assign pend = acc_q[PendBits-1:0] & ~({PendBits{1'b1}} << cnt_q[2:0]);
	assign wsat = (field_width > MaxW) ? MaxW : field_width;
	assign val_ext  = AccW'(field_value);
	assign val_mask = ~({AccW{1'b1}} << wsat);
	assign flush_byte = ByteBits'({1'b0, pend} << (4'd8 - {1'b0, cnt_q[2:0]}));

	always_comb begin
		if (action == ACT_FLUSH) begin
			acc_d = AccW'(flush_byte);
			cnt_d = (cnt_q[2:0] != 3'd0) ? CntW'(ByteBits) : '0;
		end else begin
			acc_d = (AccW'(pend) << wsat) | (val_ext & val_mask);
			cnt_d = CntW'(cnt_q[2:0]) + CntW'(wsat);
		end
	end

	assign emit_sh  = cnt_q - CntW'(ByteBits);
	assign out_byte = ByteBits'(acc_q >> emit_sh);

	// last byte when fewer than a byte of bits stays behind it
	assign status.load_emits = (cnt_d >= CntW'(ByteBits));
	assign status.emit_last  = (emit_sh < CntW'(ByteBits));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			acc_q <= acc_d;
			cnt_q <= cnt_d;
		end else if (cmd.ack) begin
			cnt_q <= emit_sh;
		end
	end

endmodule

// ----- hdl/msb_first_bit_packer.sv -----
// top level of the msb-first bit packer
//
// channel  dir  fields
// s_axis   in   tuser: action; tdata: field_width[5:0], field_value[37:6]
// m_axis   out  tdata: out_byte[7:0]; tlast: last_of_run
//
// an item is accepted first, then the output shifter hands out each byte
// it completes, one byte per cycle while m_axis_tready is high; an item
// that completes no byte goes straight back to accepting
// the input is not ready while bytes of the current item are pending
// a stalled output holds its byte; reset clears the pending bits
module msb_first_bit_packer import mbp_pkg::*; #(
	parameter int unsigned MAX_FIELD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // field_width[5:0], field_value[37:6], zero pad
	input  logic        s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
	output logic        m_axis_tlast
);

	dp_cmd_t    cmd;
	dp_status_t status;

	mbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.cmd       (cmd)
	);

	mbp_dp #(
		.MAX_FIELD_BITS (MAX_FIELD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.action      (action_t'(s_axis_tuser)),
		.field_width (s_axis_tdata[5:0]),
		.field_value (s_axis_tdata[37:6]),
		.status      (status),
		.out_byte    (m_axis_tdata)
	);

	assign m_axis_tlast = status.emit_last;

`ifndef ASSERT_OFF
	// one item at a time: no accept while bytes are handed out
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while output pending");

	// a run only ends on its marked byte
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("run ended without last byte");

	// a flush gives at most one byte
	a_flush_single: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser) |=>
		(!m_axis_tvalid || m_axis_tlast))
		else $error("flush gave more than one byte");

	// a zero-width append gives no byte
	a_zero_width: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !s_axis_tuser && (s_axis_tdata[5:0] == 6'd0))
		|=> !m_axis_tvalid)
		else $error("zero-width append gave a byte");
`endif

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the msb-first bit packer
module testbench;
	import mbp_pkg::*;

	localparam int unsigned FieldCap = 32;
	localparam int PlanRows = 24;
	localparam int RandomItems = 106;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} packed_byte_t;

	// typed < 0: expectation comes from the packing model
	// typed >= 0: that many bytes, earliest in typed_bytes[31:24]
	typedef struct {
		action_t     act;
		logic [5:0]  width;
		logic [31:0] value;
		int          typed;
		logic [31:0] typed_bytes;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // field_width[5:0], field_value[37:6], zero pad
	logic        s_axis_tuser = 1'b0;  // action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;  // out_byte[7:0]
	logic        m_axis_tlast;

	// model state of the packer
	logic [6:0] held_bits = '0;
	logic [2:0] held_count = '0;

	packed_byte_t owed_bytes[$];
	packed_byte_t fresh_bytes[$];
	bit calm = 1'b0;
	int errors = 0;
	int items_sent = 0;
	int flushes_sent = 0;
	int bytes_checked = 0;

	stim_row_t plan [PlanRows] = '{
		'{ACT_FLUSH,  6'd0,  32'h0000_0000, 0, 32'h0},
		'{ACT_APPEND, 6'd0,  32'hFFFF_FFFF, 0, 32'h0},
		'{ACT_APPEND, 6'd8,  32'h0000_00A5, 1, 32'hA500_0000},
		'{ACT_APPEND, 6'd32, 32'hDEAD_BEEF, 4, 32'hDEAD_BEEF},
		'{ACT_APPEND, 6'd32, 32'h0000_0000, 4, 32'h0000_0000},
		'{ACT_APPEND, 6'd32, 32'hFFFF_FFFF, 4, 32'hFFFF_FFFF},
		'{ACT_APPEND, 6'd1,  32'hFFFF_FFFF, 0, 32'h0},
		'{ACT_FLUSH,  6'd63, 32'hFFFF_FFFF, 1, 32'h8000_0000},
		'{ACT_APPEND, 6'd63, 32'h1234_5678, 4, 32'h1234_5678},
		'{ACT_APPEND, 6'd33, 32'hFFFF_FFFF, 4, 32'hFFFF_FFFF},
		'{ACT_APPEND, 6'd3,  32'h0000_0005, -1, 32'h0},
		'{ACT_APPEND, 6'd7,  32'h0000_007F, -1, 32'h0},
		'{ACT_APPEND, 6'd32, 32'hA5A5_A5A5, -1, 32'h0},
		'{ACT_APPEND, 6'd6,  32'hFFFF_FFC0, -1, 32'h0},
		'{ACT_APPEND, 6'd7,  32'h0000_0055, -1, 32'h0},
		'{ACT_APPEND, 6'd1,  32'h0000_0000, -1, 32'h0},
		'{ACT_APPEND, 6'd7,  32'h0000_002A, -1, 32'h0},
		'{ACT_APPEND, 6'd32, 32'h8000_0001, -1, 32'h0},
		'{ACT_FLUSH,  6'd17, 32'h5A5A_5A5A, -1, 32'h0},
		'{ACT_FLUSH,  6'd0,  32'h0000_0000, 0, 32'h0},
		'{ACT_APPEND, 6'd5,  32'hFFFF_FFFF, -1, 32'h0},
		'{ACT_FLUSH,  6'd32, 32'h0000_0000, -1, 32'h0},
		'{ACT_APPEND, 6'd31, 32'h7FFF_FFFF, -1, 32'h0},
		'{ACT_APPEND, 6'd58, 32'h0000_0001, -1, 32'h0}
	};

	msb_first_bit_packer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#200000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// bytes the packer must emit for one item, into fresh_bytes
	task automatic pack_item(input action_t act, input logic [5:0] width, input logic [31:0] value);
		logic [63:0] acc;
		int wid;
		int total;
		fresh_bytes.delete();
		if (act == ACT_FLUSH) begin
			if (held_count != 0)
				fresh_bytes.push_back({8'({1'b0, held_bits} << (8 - held_count)), 1'b1});
			held_bits = '0;
			held_count = '0;
		end else begin
			wid = (width > FieldCap) ? FieldCap : width;
			if (wid != 0) begin
				acc = (64'(held_bits) << wid) | (64'(value) & ((64'd1 << wid) - 64'd1));
				total = held_count + wid;
				while (total >= 8) begin
					total -= 8;
					fresh_bytes.push_back({8'(acc >> total), total < 8});
				end
				held_count = 3'(total);
				held_bits = 7'(acc & ((64'd1 << total) - 64'd1));
			end
		end
	endtask

	task automatic send_item(input action_t act, input logic [5:0] width, input logic [31:0] value,
			input int typed, input logic [31:0] typed_bytes);
		while (!calm && $urandom_range(99) < 23) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {2'b00, value, width};
		do @(posedge clk); while (!s_axis_tready);
		pack_item(act, width, value);
		if (typed < 0) begin
			foreach (fresh_bytes[k])
				owed_bytes.push_back(fresh_bytes[k]);
		end else begin
			for (int k = 0; k < typed; k++)
				owed_bytes.push_back({typed_bytes[31 - 8 * k -: 8], k == typed - 1});
		end
		items_sent++;
		if (act == ACT_FLUSH)
			flushes_sent++;
	endtask

	// output side: random stalls unless calm, compare every accepted item
	always @(posedge clk) begin
		packed_byte_t want;
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (owed_bytes.size() == 0) begin
				$error("unexpected output item: out_byte %02h last_of_run %0b",
					m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				want = owed_bytes.pop_front();
				if (m_axis_tdata !== want.data) begin
					$error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last_of_run: expected %0b, got %0b", want.last, m_axis_tlast);
					errors++;
				end
				bytes_checked++;
			end
		end
	end

	initial begin
		action_t act;
		logic [5:0] width;
		int pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < PlanRows; r++)
			send_item(plan[r].act, plan[r].width, plan[r].value, plan[r].typed,
				plan[r].typed_bytes);

		for (int i = 0; i < RandomItems; i++) begin
			calm = (i >= 50 && i < 90);
			pick = $urandom_range(99);
			act = ACT_APPEND;
			if (pick < 12)
				act = ACT_FLUSH;
			else if (pick < 20)
				width = 6'd0;
			else if (pick < 30)
				width = 6'($urandom_range(63, 33));
			else if (pick < 60)
				width = 6'($urandom_range(7, 1));
			else
				width = 6'($urandom_range(32, 1));
			if (act == ACT_FLUSH)
				width = 6'($urandom_range(63));
			send_item(act, width, $urandom, -1, 32'h0);
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b1;

		while (owed_bytes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d items (%0d flushes), checked %0d output bytes",
			items_sent, flushes_sent, bytes_checked);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/mbp_pkg.sv
hdl/mbp_ctrl.sv
hdl/mbp_dp.sv
hdl/msb_first_bit_packer.sv
test/testbench.sv
